@@ rtl/assert_macros.svh @@
// Concurrent assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clock edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Check prop on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/prc_pkg.sv @@
`default_nettype none

package prc_pkg;

	localparam logic [6:0] IP_BASE    = 7'd14;
	localparam logic [6:0] L4_BASE    = 7'd34;
	localparam logic [6:0] QUOTE_BASE = 7'd42;
	localparam logic [6:0] POS_MAX    = 7'd127;

	localparam logic [7:0] MIN_FRAME = 8'd34;
	localparam logic [7:0] MIN_ICMP  = 8'd66;
	localparam logic [7:0] MIN_TCP   = 8'd38;

	localparam logic [3:0] IP_VERSION  = 4'd4;
	localparam logic [3:0] IHL_MAX     = 4'd5;
	localparam logic [7:0] PROTO_ICMP   = 8'd1;
	localparam logic [7:0] PROTO_TCP    = 8'd6;
	localparam logic [7:0] TYPE_UNREACH = 8'd3;

	localparam logic [1:0] VERDICT_NONE     = 2'd0;
	localparam logic [1:0] VERDICT_CONTINUE = 2'd1;
	localparam logic [1:0] VERDICT_DONE     = 2'd2;

	localparam logic KIND_ICMP = 1'b0;
	localparam logic KIND_TCP  = 1'b1;

	localparam logic [2:0] REG_OUR_ADDRESS    = 3'd0;
	localparam logic [2:0] REG_TARGET_ADDRESS = 3'd1;
	localparam logic [2:0] REG_OUR_PORT       = 3'd2;
	localparam logic [2:0] REG_TARGET_PORT    = 3'd3;
	localparam logic [2:0] REG_PROBE_IDENT    = 3'd4;

	typedef struct packed {
		logic [31:0] our_address;
		logic [31:0] target_address;
		logic [15:0] our_port;
		logic [15:0] target_port;
		logic [15:0] probe_ident;
	} prc_cfg_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic        kind;
		logic [31:0] source;
	} prc_result_t;

	// k = 0 selects the most significant byte
	function automatic logic [7:0] addr_byte(input logic [31:0] addr, input logic [1:0] k);
		logic [7:0] r;
		case (k)
			2'd0:    r = addr[31:24];
			2'd1:    r = addr[23:16];
			2'd2:    r = addr[15:8];
			default: r = addr[7:0];
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/prc_checker.sv @@
`default_nettype none

module prc_checker import prc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  frame_byte,
	input  wire logic        last_byte,
	input  wire prc_cfg_t    cfg,
	output prc_result_t      result
);

	logic [6:0]  pos_q;
	logic [7:0]  protocol_q;
	logic [31:0] source_q;
	logic        header_ok_q;
	logic        icmp_ok_q;
	logic        tcp_ok_q;
	logic        unreach_q;
	logic [15:0] shift_q;

	logic [15:0] shift_u;
	logic [7:0]  protocol_u;
	logic [31:0] source_u;
	logic        header_ok_u;
	logic        icmp_ok_u;
	logic        tcp_ok_u;
	logic        unreach_u;
	logic [1:0]  k;
	logic [7:0]  len;

	assign shift_u = {shift_q[7:0], frame_byte};
	assign k       = pos_q[1:0] + 2'd2;
	assign len     = {1'b0, pos_q} + 8'd1;

	always_comb begin
		protocol_u  = protocol_q;
		source_u    = source_q;
		header_ok_u = header_ok_q;
		icmp_ok_u   = icmp_ok_q;
		tcp_ok_u    = tcp_ok_q;
		unreach_u   = unreach_q;
		if (pos_q == IP_BASE) begin
			if (frame_byte[7:4] != IP_VERSION || frame_byte[3:0] > IHL_MAX)
				header_ok_u = 1'b0;
		end else if (pos_q == IP_BASE + 7'd9) begin
			protocol_u = frame_byte;
		end else if (pos_q >= IP_BASE + 7'd12 && pos_q <= IP_BASE + 7'd15) begin
			source_u = {source_q[23:0], frame_byte};
			if (frame_byte != addr_byte(cfg.target_address, k))
				tcp_ok_u = 1'b0;
		end else if (pos_q >= IP_BASE + 7'd16 && pos_q <= IP_BASE + 7'd19) begin
			if (frame_byte != addr_byte(cfg.our_address, k))
				header_ok_u = 1'b0;
		end else if (pos_q == L4_BASE) begin
			unreach_u = (frame_byte == TYPE_UNREACH);
		end else if (pos_q == L4_BASE + 7'd1) begin
			if (shift_u != cfg.target_port)
				tcp_ok_u = 1'b0;
		end else if (pos_q == L4_BASE + 7'd3) begin
			if (shift_u != cfg.our_port)
				tcp_ok_u = 1'b0;
		end else if (pos_q == QUOTE_BASE + 7'd5) begin
			if (shift_u != cfg.probe_ident)
				icmp_ok_u = 1'b0;
		end else if (pos_q == QUOTE_BASE + 7'd9) begin
			if (frame_byte != PROTO_TCP)
				icmp_ok_u = 1'b0;
		end else if (pos_q >= QUOTE_BASE + 7'd12 && pos_q <= QUOTE_BASE + 7'd15) begin
			if (frame_byte != addr_byte(cfg.our_address, k))
				icmp_ok_u = 1'b0;
		end else if (pos_q == QUOTE_BASE + 7'd21) begin
			if (shift_u != cfg.our_port)
				icmp_ok_u = 1'b0;
		end else if (pos_q == QUOTE_BASE + 7'd23) begin
			if (shift_u != cfg.target_port)
				icmp_ok_u = 1'b0;
		end
	end

	always_comb begin
		result.verdict = VERDICT_NONE;
		result.kind    = KIND_ICMP;
		result.source  = source_u;
		if (header_ok_u && len >= MIN_FRAME) begin
			if (protocol_u == PROTO_ICMP) begin
				if (len >= MIN_ICMP && icmp_ok_u)
					result.verdict = unreach_u ? VERDICT_DONE : VERDICT_CONTINUE;
			end else if (protocol_u == PROTO_TCP) begin
				if (len >= MIN_TCP && tcp_ok_u) begin
					result.verdict = VERDICT_DONE;
					result.kind    = KIND_TCP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			protocol_q  <= '0;
			source_q    <= '0;
			header_ok_q <= 1'b1;
			icmp_ok_q   <= 1'b1;
			tcp_ok_q    <= 1'b1;
			unreach_q   <= 1'b0;
			shift_q     <= '0;
		end else if (step) begin
			if (last_byte) begin
				pos_q       <= '0;
				protocol_q  <= '0;
				source_q    <= '0;
				header_ok_q <= 1'b1;
				icmp_ok_q   <= 1'b1;
				tcp_ok_q    <= 1'b1;
				unreach_q   <= 1'b0;
				shift_q     <= '0;
			end else begin
				if (pos_q < POS_MAX)
					pos_q <= pos_q + 7'd1;
				protocol_q  <= protocol_u;
				source_q    <= source_u;
				header_ok_q <= header_ok_u;
				icmp_ok_q   <= icmp_ok_u;
				tcp_ok_q    <= tcp_ok_u;
				unreach_q   <= unreach_u;
				shift_q     <= shift_u;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/probe_reply_classifier.sv @@
`default_nettype none
`include "assert_macros.svh"

// Probe reply classifier: takes a captured Ethernet frame one byte per item and,
// on the item marked last_byte, delivers one verdict saying whether the frame
// answers our outstanding TCP SYN probe (an ICMP quote of it or a TCP reply from
// the target), along with the reply type and the outer IPv4 source address.
// Bytes are taken at one per cycle: each byte passes an input register, is
// compared against the field at its fixed offset, and the verdict lands in an
// output register, so a frame byte enters every cycle unless a verdict is still
// waiting to be taken and the next last byte needs the output register.
// The verdict is presented from the output register, which is loaded when its last byte leaves the input register.
// Configuration registers are to be written by the user through the cfg port
// only while no frame is in flight; the block itself does not enforce this.

module probe_reply_classifier import prc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  frame_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       verdict,
	output logic             reply_kind,
	output logic [31:0]      reply_source
);

	prc_cfg_t    cfg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        fire_s1;
	logic        out_valid_q;
	prc_result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_OUR_ADDRESS:    cfg_q.our_address    <= cfg_data;
				REG_TARGET_ADDRESS: cfg_q.target_address <= cfg_data;
				REG_OUR_PORT:       cfg_q.our_port       <= cfg_data[15:0];
				REG_TARGET_PORT:    cfg_q.target_port    <= cfg_data[15:0];
				REG_PROBE_IDENT:    cfg_q.probe_ident    <= cfg_data[15:0];
				default:            ;
			endcase
		end
	end

	assign fire_s1  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= frame_byte;
			last_s1 <= last_byte;
		end
	end

	prc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (fire_s1),
		.frame_byte (byte_s1),
		.last_byte  (last_s1),
		.cfg        (cfg_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			verdict      <= result.verdict;
			reply_kind   <= result.kind;
			reply_source <= result.source;
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_RST(a_verdict_code, clk, arst_n, out_valid_q |-> verdict <= VERDICT_DONE,
		"bad verdict code")
	`ASSERT_RST(a_tcp_done, clk, arst_n,
		(out_valid_q && reply_kind == KIND_TCP) |-> verdict == VERDICT_DONE, "TCP reply not done")
	`ASSERT_RST(a_stall_cause, clk, arst_n,
		!in_ready |-> (valid_s1 && last_s1 && out_valid_q && !out_ready),
		"input stalled without cause")
	`ASSERT_RST(a_result_load, clk, arst_n, (fire_s1 && last_s1) |=> out_valid_q, "verdict lost")

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

module tb import prc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_FRAME = 140;

	typedef enum {FR_ICMP, FR_TCP, FR_OTHER, FR_NOISE} frame_kind_t;

	typedef struct {
		logic [7:0] data;
		logic       is_last;
	} frame_item_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  frame_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  verdict;
	logic        reply_kind;
	logic [31:0] reply_source;

	probe_reply_classifier uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.frame_byte   (frame_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.verdict      (verdict),
		.reply_kind   (reply_kind),
		.reply_source (reply_source)
	);

	frame_item_t pending [$];
	prc_result_t verdicts_due [$];
	prc_cfg_t    cfg = '0;

	logic [6:0]  pos = '0;
	logic [7:0]  proto = '0;
	logic [31:0] src = '0;
	logic        hdr_ok = 1'b1;
	logic        icmp_ok = 1'b1;
	logic        tcp_ok = 1'b1;
	logic        unreach = 1'b0;
	logic [15:0] shift = '0;

	bit calm = 1'b0;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int mismatches = 0;
	int stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] octet_of(input logic [31:0] addr, input logic [1:0] k);
		return 8'(addr >> (24 - 8 * k));
	endfunction

	task automatic classify_byte(input logic [7:0] b, input logic is_last);
		prc_result_t r;
		int len;
		shift = {shift[7:0], b};
		if (pos == IP_BASE) begin
			if (b[7:4] != IP_VERSION || b[3:0] > IHL_MAX) hdr_ok = 1'b0;
		end else if (pos == IP_BASE + 7'd9) begin
			proto = b;
		end else if (pos >= IP_BASE + 7'd12 && pos <= IP_BASE + 7'd15) begin
			src = {src[23:0], b};
			if (b != octet_of(cfg.target_address, 2'(pos - (IP_BASE + 7'd12)))) tcp_ok = 1'b0;
		end else if (pos >= IP_BASE + 7'd16 && pos <= IP_BASE + 7'd19) begin
			if (b != octet_of(cfg.our_address, 2'(pos - (IP_BASE + 7'd16)))) hdr_ok = 1'b0;
		end else if (pos == L4_BASE) begin
			unreach = (b == TYPE_UNREACH);
		end else if (pos == L4_BASE + 7'd1) begin
			if (shift != cfg.target_port) tcp_ok = 1'b0;
		end else if (pos == L4_BASE + 7'd3) begin
			if (shift != cfg.our_port) tcp_ok = 1'b0;
		end else if (pos == QUOTE_BASE + 7'd5) begin
			if (shift != cfg.probe_ident) icmp_ok = 1'b0;
		end else if (pos == QUOTE_BASE + 7'd9) begin
			if (b != PROTO_TCP) icmp_ok = 1'b0;
		end else if (pos >= QUOTE_BASE + 7'd12 && pos <= QUOTE_BASE + 7'd15) begin
			if (b != octet_of(cfg.our_address, 2'(pos - (QUOTE_BASE + 7'd12)))) icmp_ok = 1'b0;
		end else if (pos == QUOTE_BASE + 7'd21) begin
			if (shift != cfg.our_port) icmp_ok = 1'b0;
		end else if (pos == QUOTE_BASE + 7'd23) begin
			if (shift != cfg.target_port) icmp_ok = 1'b0;
		end

		if (!is_last) begin
			if (pos != POS_MAX) pos = pos + 7'd1;
		end else begin
			len = int'(pos) + 1;
			r.verdict = VERDICT_NONE;
			r.kind = KIND_ICMP;
			r.source = src;
			if (hdr_ok && len >= int'(MIN_FRAME)) begin
				if (proto == PROTO_ICMP) begin
					if (len >= int'(MIN_ICMP) && icmp_ok)
						r.verdict = unreach ? VERDICT_DONE : VERDICT_CONTINUE;
				end else if (proto == PROTO_TCP) begin
					if (len >= int'(MIN_TCP) && tcp_ok) begin
						r.verdict = VERDICT_DONE;
						r.kind = KIND_TCP;
					end
				end
			end
			verdicts_due.push_back(r);
			pos = '0;
			proto = '0;
			src = '0;
			hdr_ok = 1'b1;
			icmp_ok = 1'b1;
			tcp_ok = 1'b1;
			unreach = 1'b0;
			shift = '0;
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_OUR_ADDRESS:    cfg.our_address = val;
			REG_TARGET_ADDRESS: cfg.target_address = val;
			REG_OUR_PORT:       cfg.our_port = val[15:0];
			REG_TARGET_PORT:    cfg.target_port = val[15:0];
			REG_PROBE_IDENT:    cfg.probe_ident = val[15:0];
			default: ;
		endcase
	endtask

	task automatic build_frame(input frame_kind_t kind, input int len, input logic [7:0] l4_type,
			input logic [7:0] ver_ihl, input bit corrupt);
		logic [7:0] fb [MAX_FRAME];
		int spots [25] = '{14, 23, 26, 27, 28, 29, 30, 31, 32, 33, 34, 35, 36, 37,
			46, 47, 51, 54, 55, 56, 57, 62, 63, 64, 65};
		int at;
		frame_item_t item;
		for (int i = 0; i < MAX_FRAME; i++) fb[i] = 8'($urandom);
		if (kind != FR_NOISE) begin
			fb[14] = ver_ihl;
			{fb[30], fb[31], fb[32], fb[33]} = cfg.our_address;
		end
		case (kind)
			FR_ICMP: begin
				fb[23] = PROTO_ICMP;
				fb[34] = l4_type;
				{fb[46], fb[47]} = cfg.probe_ident;
				fb[51] = PROTO_TCP;
				{fb[54], fb[55], fb[56], fb[57]} = cfg.our_address;
				{fb[62], fb[63]} = cfg.our_port;
				{fb[64], fb[65]} = cfg.target_port;
			end
			FR_TCP: begin
				fb[23] = PROTO_TCP;
				{fb[26], fb[27], fb[28], fb[29]} = cfg.target_address;
				{fb[34], fb[35]} = cfg.target_port;
				{fb[36], fb[37]} = cfg.our_port;
			end
			FR_OTHER: begin
				if (fb[23] == PROTO_ICMP || fb[23] == PROTO_TCP) fb[23] = PROTO_UDP;
			end
			default: ;
		endcase
		if (corrupt) begin
			at = spots[$urandom_range(0, 24)];
			fb[at] = fb[at] ^ 8'($urandom_range(1, 255));
		end
		if (len < 1) len = 1;
		if (len > MAX_FRAME) len = MAX_FRAME;
		for (int i = 0; i < len; i++) begin
			item.data = fb[i];
			item.is_last = (i == len - 1);
			pending.push_back(item);
		end
	endtask

	task automatic random_frames(input int byte_goal);
		int sent;
		int frames;
		int pick;
		int len;
		int band;
		frame_kind_t kind;
		logic [7:0] l4_type;
		logic [7:0] ver_ihl;
		bit corrupt;
		sent = 0;
		frames = 0;
		while (sent < byte_goal || frames < 3) begin
			pick = $urandom_range(0, 99);
			band = $urandom_range(0, 9);
			l4_type = $urandom_range(0, 1) ? TYPE_UNREACH : 8'($urandom);
			ver_ihl = {IP_VERSION, 4'($urandom_range(0, 5))};
			corrupt = 1'b0;
			kind = $urandom_range(0, 1) ? FR_ICMP : FR_TCP;
			if (pick < 35) begin
				kind = FR_ICMP;
			end else if (pick < 65) begin
				kind = FR_TCP;
			end else if (pick < 80) begin
				corrupt = 1'b1;
			end else if (pick < 88) begin
				kind = FR_OTHER;
			end else if (pick < 93) begin
				ver_ihl = 8'($urandom);
			end else begin
				kind = FR_NOISE;
			end
			case (kind)
				FR_ICMP:
					len = (band == 0) ? $urandom_range(34, 65) :
						(band == 1) ? $urandom_range(81, MAX_FRAME) : $urandom_range(66, 80);
				FR_TCP:
					len = (band == 0) ? $urandom_range(20, 37) :
						(band == 1) ? $urandom_range(61, MAX_FRAME) : $urandom_range(38, 60);
				FR_OTHER: len = $urandom_range(34, 60);
				default:  len = $urandom_range(1, 100);
			endcase
			build_frame(kind, len, l4_type, ver_ihl, corrupt);
			sent += len;
			frames++;
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (pending.size() != 0 || in_valid || verdicts_due.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) classify_byte(frame_byte, last_byte);
			if (!in_valid || in_ready) begin
				if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
					nxt = pending.pop_front();
					in_valid <= 1'b1;
					frame_byte <= nxt.data;
					last_byte <= nxt.is_last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		prc_result_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: verdict %0d kind %0d source %h",
							verdict, reply_kind, reply_source);
				end else begin
					exp_r = verdicts_due.pop_front();
					if (verdict !== exp_r.verdict || reply_kind !== exp_r.kind ||
							reply_source !== exp_r.source) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: verdict %0d/%0d kind %0d/%0d source %h/%h (exp/got)",
								exp_r.verdict, verdict, exp_r.kind, reply_kind,
								exp_r.source, reply_source);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (hold_request && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 33);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames under the reset settings
		build_frame(FR_NOISE, 1, 8'h00, 8'h45, 1'b0);
		build_frame(FR_TCP, 28, 8'h00, 8'h45, 1'b0);
		build_frame(FR_TCP, 33, 8'h00, 8'h45, 1'b0);
		build_frame(FR_TCP, 37, 8'h00, 8'h45, 1'b0);
		build_frame(FR_TCP, 38, 8'h00, 8'h45, 1'b0);
		build_frame(FR_TCP, 40, 8'h00, 8'h40, 1'b0);
		build_frame(FR_TCP, 40, 8'h00, 8'h46, 1'b0);
		build_frame(FR_TCP, 40, 8'h00, 8'h65, 1'b0);
		build_frame(FR_ICMP, 65, TYPE_UNREACH, 8'h45, 1'b0);
		build_frame(FR_ICMP, 66, TYPE_UNREACH, 8'h45, 1'b0);
		build_frame(FR_ICMP, 66, 8'h00, 8'h45, 1'b0);
		build_frame(FR_ICMP, MAX_FRAME, 8'h0b, 8'h45, 1'b0);
		build_frame(FR_OTHER, 40, 8'h00, 8'h45, 1'b0);
		build_frame(FR_NOISE, 1, 8'h00, 8'h45, 1'b0);
		wait_idle();

		write_reg(REG_OUR_ADDRESS, 32'hffff_ffff);
		write_reg(REG_TARGET_ADDRESS, 32'hffff_ffff);
		write_reg(REG_OUR_PORT, 32'h0000_ffff);
		write_reg(REG_TARGET_PORT, 32'h0000_ffff);
		write_reg(REG_PROBE_IDENT, 32'h0000_ffff);
		@(posedge clk) cfg_write_en <= 1'b0;
		@(negedge clk);
		calm = 1'b1;
		build_frame(FR_ICMP, 66, TYPE_UNREACH, 8'h45, 1'b0);
		build_frame(FR_TCP, 38, 8'h00, 8'h45, 1'b0);
		random_frames(180);
		wait_idle();
		calm = 1'b0;

		write_reg(REG_OUR_ADDRESS, $urandom);
		write_reg(REG_TARGET_ADDRESS, $urandom);
		write_reg(REG_OUR_PORT, $urandom);
		write_reg(REG_TARGET_PORT, $urandom);
		write_reg(REG_PROBE_IDENT, $urandom);
		write_reg(REG_SPARE_LO, $urandom);
		write_reg(REG_SPARE_HI, $urandom);
		@(posedge clk) cfg_write_en <= 1'b0;
		@(negedge clk);
		hold_request = 1'b1;
		random_frames(180);
		wait_idle();

		write_reg(REG_OUR_ADDRESS, 32'h0000_0000);
		write_reg(REG_TARGET_ADDRESS, $urandom);
		write_reg(REG_OUR_PORT, 32'h0000_0000);
		write_reg(REG_TARGET_PORT, $urandom);
		write_reg(REG_PROBE_IDENT, $urandom);
		@(posedge clk) cfg_write_en <= 1'b0;
		@(negedge clk);
		random_frames(180);
		wait_idle();

		repeat (10) @(posedge clk);
		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
